@@ src/asst_pkg.sv @@
// ----------------------------------------------------------------------------
// asst_pkg: shared definitions for the answer stream sequence tracker
// Message kinds, status codes, answer states, limits and the header layout.
// ----------------------------------------------------------------------------
package asst_pkg;

  // Field widths.
  localparam int unsigned KindW   = 3;
  localparam int unsigned EpochW  = 64;
  localparam int unsigned SeqW    = 64;
  localparam int unsigned PlenW   = 16;
  localparam int unsigned LenW    = 21;
  localparam int unsigned MarkW   = 7;
  localparam int unsigned StatusW = 3;
  localparam int unsigned ModeW   = 3;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 21;
  // Sum width for the length checks: answer + payload + reserve.
  localparam int unsigned SumW    = LenW + 2;

  // Limits and reserves.
  localparam logic [LenW-1:0]  TEXT_LIMIT_MAX = LenW'(1048576);
  localparam logic [MarkW-1:0] MARKER_MAX     = MarkW'(64);
  localparam logic [SumW-1:0]  GAP_RESERVE    = SumW'(16);

  // Register reset values.
  localparam logic [LenW-1:0]  TEXT_LIMIT_RST  = LenW'(524288);
  localparam logic [MarkW-1:0] GAP_MARKER_RST  = MarkW'(28);
  localparam logic [PlenW-1:0] MAX_PAYLOAD_RST = PlenW'(4096);

  // Register indexes.
  localparam logic [CfgIdxW-1:0] REG_TEXT_LIMIT  = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_GAP_MARKER  = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_MAX_PAYLOAD = 2'd2;

  // Message kinds.
  localparam logic [KindW-1:0] KIND_STARTED   = 3'd0;
  localparam logic [KindW-1:0] KIND_PROGRESS  = 3'd1;
  localparam logic [KindW-1:0] KIND_DELTA     = 3'd2;
  localparam logic [KindW-1:0] KIND_COMPLETED = 3'd3;
  localparam logic [KindW-1:0] KIND_FAILED    = 3'd4;
  localparam logic [KindW-1:0] KIND_CANCELLED = 3'd5;
  localparam logic [KindW-1:0] KIND_CLEARED   = 3'd6;

  // Result status codes.
  localparam logic [StatusW-1:0] ST_IGNORED  = 3'd0;
  localparam logic [StatusW-1:0] ST_DROPPED  = 3'd1;
  localparam logic [StatusW-1:0] ST_APPLIED  = 3'd2;
  localparam logic [StatusW-1:0] ST_APPENDED = 3'd3;
  localparam logic [StatusW-1:0] ST_FULL     = 3'd4;
  localparam logic [StatusW-1:0] ST_PROGRESS = 3'd5;
  localparam logic [StatusW-1:0] ST_ERROR    = 3'd6;

  // Answer states.
  localparam logic [ModeW-1:0] M_IDLE      = 3'd0;
  localparam logic [ModeW-1:0] M_WAITING   = 3'd2;
  localparam logic [ModeW-1:0] M_THINKING  = 3'd3;
  localparam logic [ModeW-1:0] M_STREAMING = 3'd4;
  localparam logic [ModeW-1:0] M_COMPLETED = 3'd5;
  localparam logic [ModeW-1:0] M_FAILED    = 3'd6;
  localparam logic [ModeW-1:0] M_CANCELLED = 3'd7;
  localparam logic [ModeW-1:0] M_CONNECTING = 3'd1;

  // Stream bus widths.
  localparam int unsigned InDataW  = 144;
  localparam int unsigned InUserW  = 4;
  localparam int unsigned OutDataW = 144;
  localparam int unsigned OutUserW = 3;

  // One message header as held in the input register.
  typedef struct packed {
    logic [KindW-1:0]  kind;
    logic [EpochW-1:0] msg_epoch;
    logic [SeqW-1:0]   msg_sequence;
    logic [PlenW-1:0]  payload_length;
    logic              continuation;
  } hdr_t;

endpackage

@@ src/answer_stream_sequence_tracker.sv @@
// Flow: an accepted header word loads the input register; its result word is loaded
// into the result register when that register is free or being emptied.
// Throughput: one header per cycle unless the result side stalls; the input
// register takes one more word while the downstream side holds a result word.
// Reset: synchronous; clears all stream state, loads the register defaults
// and empties both stages. No clearing pass is needed.
// ----------------------------------------------------------------------------
// answer_stream_sequence_tracker
// Tracks epoch, sequence, text lengths and flags of a streamed answer, one
// message header per word, and reports status and write offsets.
// ----------------------------------------------------------------------------
module answer_stream_sequence_tracker (
  input  logic                                clk,
  input  logic                                rst,
  // Configuration write port.
  input  logic                                cfg_we,
  input  logic [asst_pkg::CfgIdxW-1:0]        cfg_index,
  input  logic [asst_pkg::CfgW-1:0]           cfg_data,
  // Header stream.
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // msg_epoch[63:0], msg_sequence[127:64], payload_length[143:128]
  input  logic [asst_pkg::InDataW-1:0]        s_axis_tdata,
  // kind[2:0], continuation[3]
  input  logic [asst_pkg::InUserW-1:0]        s_axis_tuser,
  // Result stream.
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // marker_inserted[0], write_offset[21:1], answer_length[42:22],
  // progress_length[58:43], error_length[74:59], answer_state[77:75],
  // current_epoch[141:78], gap_seen[142], truncated[143]
  output logic [asst_pkg::OutDataW-1:0]       m_axis_tdata,
  // status[2:0]
  output logic [asst_pkg::OutUserW-1:0]       m_axis_tuser
);

  // Configuration registers.
  logic [asst_pkg::LenW-1:0]  text_limit;
  logic [asst_pkg::MarkW-1:0] gap_marker_bytes;
  logic [asst_pkg::PlenW-1:0] max_payload;

  // Stream state.
  logic [asst_pkg::ModeW-1:0]  mode, mode_next;
  logic [asst_pkg::EpochW-1:0] epoch_reg, epoch_reg_next;
  logic [asst_pkg::SeqW-1:0]   last_seq, last_seq_next;
  logic [asst_pkg::LenW-1:0]   answer_len, answer_len_next;
  logic [asst_pkg::PlenW-1:0]  progress_len, progress_len_next;
  logic [asst_pkg::PlenW-1:0]  error_len, error_len_next;
  logic                        gap_flag, gap_flag_next;
  logic                        trunc_flag, trunc_flag_next;

  // Pipeline registers.
  logic                in_valid;
  asst_pkg::hdr_t      in_hdr;
  logic                proc;

  // Per-word results.
  logic [asst_pkg::StatusW-1:0] status;
  logic                         mark;
  logic [asst_pkg::LenW-1:0]    woff;

  // Clamped registers.
  logic [asst_pkg::LenW-1:0]  limit;
  logic [asst_pkg::MarkW-1:0] marker;

  // Handshake: a header is worked on when the result register is free.
  assign proc          = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || proc;

  // Configuration writes; index three is not a register.
  always_ff @(posedge clk) begin
    if (rst) begin
      text_limit       <= asst_pkg::TEXT_LIMIT_RST;
      gap_marker_bytes <= asst_pkg::GAP_MARKER_RST;
      max_payload      <= asst_pkg::MAX_PAYLOAD_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        asst_pkg::REG_TEXT_LIMIT:  text_limit       <= cfg_data;
        asst_pkg::REG_GAP_MARKER:  gap_marker_bytes <= cfg_data[asst_pkg::MarkW-1:0];
        asst_pkg::REG_MAX_PAYLOAD: max_payload      <= cfg_data[asst_pkg::PlenW-1:0];
        default: ;
      endcase
    end
  end

  assign limit  = (text_limit > asst_pkg::TEXT_LIMIT_MAX) ? asst_pkg::TEXT_LIMIT_MAX
                                                           : text_limit;
  assign marker = (gap_marker_bytes > asst_pkg::MARKER_MAX) ? asst_pkg::MARKER_MAX
                                                             : gap_marker_bytes;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid <= 1'b1;
    end else if (proc) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_hdr.kind           <= s_axis_tuser[2:0];
      in_hdr.continuation   <= s_axis_tuser[3];
      in_hdr.msg_epoch      <= s_axis_tdata[63:0];
      in_hdr.msg_sequence   <= s_axis_tdata[127:64];
      in_hdr.payload_length <= s_axis_tdata[143:128];
    end
  end

  // Message rules for one header.
  always_comb begin
    logic [asst_pkg::LenW-1:0] alen;
    logic [asst_pkg::SumW-1:0] plen_ext;
    logic                      drop;
    logic                      epoch_diff;

    mode_next         = mode;
    epoch_reg_next    = epoch_reg;
    last_seq_next     = last_seq;
    answer_len_next   = answer_len;
    progress_len_next = progress_len;
    error_len_next    = error_len;
    gap_flag_next     = gap_flag;
    trunc_flag_next   = trunc_flag;
    status            = asst_pkg::ST_IGNORED;
    mark              = 1'b0;
    woff              = '0;
    alen              = answer_len;
    plen_ext          = asst_pkg::SumW'(in_hdr.payload_length);
    drop              = 1'b0;
    epoch_diff        = (epoch_reg != in_hdr.msg_epoch);

    if (in_hdr.payload_length <= max_payload) begin
      case (in_hdr.kind)
        asst_pkg::KIND_STARTED: begin
          answer_len_next   = '0;
          error_len_next    = '0;
          progress_len_next = '0;
          mode_next         = asst_pkg::M_CONNECTING;
          epoch_reg_next    = in_hdr.msg_epoch;
          last_seq_next     = in_hdr.msg_sequence;
          gap_flag_next     = 1'b0;
          trunc_flag_next   = 1'b0;
          status            = asst_pkg::ST_APPLIED;
        end
        asst_pkg::KIND_PROGRESS: begin
          if (epoch_diff) begin
            answer_len_next = '0;
            error_len_next  = '0;
            epoch_reg_next  = in_hdr.msg_epoch;
            last_seq_next   = '0;
            gap_flag_next   = 1'b0;
            trunc_flag_next = 1'b0;
          end
          progress_len_next = in_hdr.payload_length;
          mode_next = (in_hdr.payload_length == '0) ? asst_pkg::M_WAITING
                                                    : asst_pkg::M_THINKING;
          status = asst_pkg::ST_PROGRESS;
        end
        asst_pkg::KIND_DELTA: begin
          // Sequence checks first; a skip may place the gap marker.
          if (in_hdr.continuation) begin
            drop = epoch_diff;
          end else if (epoch_diff) begin
            alen            = '0;
            error_len_next  = '0;
            epoch_reg_next  = in_hdr.msg_epoch;
            last_seq_next   = in_hdr.msg_sequence;
            gap_flag_next   = 1'b0;
            trunc_flag_next = 1'b0;
          end else if (in_hdr.msg_sequence == last_seq + asst_pkg::SeqW'(1)) begin
            last_seq_next = in_hdr.msg_sequence;
          end else if (in_hdr.msg_sequence <= last_seq) begin
            drop = 1'b1;
          end else begin
            if (asst_pkg::SumW'(alen) + plen_ext + asst_pkg::GAP_RESERVE
                <= asst_pkg::SumW'(limit)) begin
              alen          = alen + asst_pkg::LenW'(marker);
              gap_flag_next = 1'b1;
              mark          = 1'b1;
            end
            last_seq_next = in_hdr.msg_sequence;
          end
          // Then the append against the limit, terminator included.
          if (drop) begin
            status = asst_pkg::ST_DROPPED;
          end else begin
            if (asst_pkg::SumW'(alen) + plen_ext + asst_pkg::SumW'(1)
                <= asst_pkg::SumW'(limit)) begin
              woff   = alen;
              alen   = alen + asst_pkg::LenW'(in_hdr.payload_length);
              status = asst_pkg::ST_APPENDED;
            end else begin
              trunc_flag_next = 1'b1;
              status          = asst_pkg::ST_FULL;
            end
            progress_len_next = '0;
            mode_next         = asst_pkg::M_STREAMING;
          end
          answer_len_next = alen;
        end
        asst_pkg::KIND_COMPLETED: begin
          progress_len_next = '0;
          mode_next         = asst_pkg::M_COMPLETED;
          status            = asst_pkg::ST_APPLIED;
        end
        asst_pkg::KIND_FAILED: begin
          if (epoch_diff) begin
            answer_len_next = '0;
            epoch_reg_next  = in_hdr.msg_epoch;
          end
          error_len_next    = in_hdr.payload_length;
          progress_len_next = '0;
          mode_next         = asst_pkg::M_FAILED;
          status            = asst_pkg::ST_ERROR;
        end
        asst_pkg::KIND_CANCELLED: begin
          progress_len_next = '0;
          mode_next         = asst_pkg::M_CANCELLED;
          status            = asst_pkg::ST_APPLIED;
        end
        asst_pkg::KIND_CLEARED: begin
          answer_len_next   = '0;
          progress_len_next = '0;
          error_len_next    = '0;
          mode_next         = asst_pkg::M_IDLE;
          epoch_reg_next    = '0;
          last_seq_next     = '0;
          gap_flag_next     = 1'b0;
          trunc_flag_next   = 1'b0;
          status            = asst_pkg::ST_APPLIED;
        end
        default: begin
          status = asst_pkg::ST_IGNORED;
        end
      endcase
    end
  end

  // Stream state update.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= asst_pkg::M_IDLE;
      epoch_reg    <= '0;
      last_seq     <= '0;
      answer_len   <= '0;
      progress_len <= '0;
      error_len    <= '0;
      gap_flag     <= 1'b0;
      trunc_flag   <= 1'b0;
    end else if (proc) begin
      mode         <= mode_next;
      epoch_reg    <= epoch_reg_next;
      last_seq     <= last_seq_next;
      answer_len   <= answer_len_next;
      progress_len <= progress_len_next;
      error_len    <= error_len_next;
      gap_flag     <= gap_flag_next;
      trunc_flag   <= trunc_flag_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (proc) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      m_axis_tuser <= status;
      m_axis_tdata <= {trunc_flag_next, gap_flag_next, epoch_reg_next, mode_next,
                       error_len_next, progress_len_next, answer_len_next, woff, mark};
    end
  end

endmodule
